/* hdl/bmrlt_pkg.sv */
package bmrlt_pkg;

    // Default sizes
    localparam int DEF_STACK_DEPTH = 128;
    localparam int DEF_COUNT_BITS  = 16;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 3;
    localparam int ARG_W    = 16;
    localparam int STATUS_W = 2;

    // Operation kinds
    localparam logic [KIND_W-1:0] OP_INC   = 3'd0;
    localparam logic [KIND_W-1:0] OP_DEC   = 3'd1;
    localparam logic [KIND_W-1:0] OP_LEFT  = 3'd2;
    localparam logic [KIND_W-1:0] OP_RIGHT = 3'd3;
    localparam logic [KIND_W-1:0] OP_IN    = 3'd4;
    localparam logic [KIND_W-1:0] OP_OUT   = 3'd5;
    localparam logic [KIND_W-1:0] OP_OPEN  = 3'd6;
    localparam logic [KIND_W-1:0] OP_CLOSE = 3'd7;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    // Source characters
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_LBRK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_RBRK  = 8'h5D;

    // One result transaction
    typedef struct packed {
        logic [KIND_W-1:0]   op_kind;
        logic [ARG_W-1:0]    op_argument;
        logic [STATUS_W-1:0] status;
        logic                last_of_run;
        logic                program_done;
    } res_t;

    // Decoded token
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
    } tok_t;

    // Stack cell control
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctl_t;

    function automatic tok_t classify(input logic [BYTE_W-1:0] b);
        tok_t t;
        t.valid = 1'b1;
        t.kind  = OP_INC;
        case (b)
            CH_PLUS:  t.kind = OP_INC;
            CH_MINUS: t.kind = OP_DEC;
            CH_LT:    t.kind = OP_LEFT;
            CH_GT:    t.kind = OP_RIGHT;
            CH_COMMA: t.kind = OP_IN;
            CH_DOT:   t.kind = OP_OUT;
            CH_LBRK:  t.kind = OP_OPEN;
            CH_RBRK:  t.kind = OP_CLOSE;
            default:  t.valid = 1'b0;
        endcase
        return t;
    endfunction

endpackage

/* hdl/bmrlt_cell.sv */
module bmrlt_cell (
    input  logic                        aclk,
    input  bmrlt_pkg::stk_ctl_t         ctl,
    input  logic [bmrlt_pkg::ARG_W-1:0] upper_data,
    input  logic [bmrlt_pkg::ARG_W-1:0] lower_data,
    output logic [bmrlt_pkg::ARG_W-1:0] data
);

    logic [bmrlt_pkg::ARG_W-1:0] data_reg;
    logic [bmrlt_pkg::ARG_W-1:0] data_next;

    // Shift down on push, up on pop, otherwise hold
    always_comb begin
        data_next = data_reg;
        if (ctl.push) begin
            data_next = upper_data;
        end else if (ctl.pop) begin
            data_next = lower_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* hdl/bmrlt_outq.sv */
module bmrlt_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [1:0]          wr_count,
    input  bmrlt_pkg::res_t     wr_res0,
    input  bmrlt_pkg::res_t     wr_res1,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output bmrlt_pkg::res_t     m_res
);

    bmrlt_pkg::res_t q_reg [4];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (count_reg != 3'd0);
    assign m_res   = q_reg[head_reg];
    assign room    = (count_reg <= 3'd2);

    // Advance pointers and occupancy
    always_comb begin
        head_next  = head_reg + {1'b0, pop};
        tail_next  = tail_reg + wr_count;
        count_next = count_reg + {1'b0, wr_count} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Store up to two results a cycle
    always_ff @(posedge aclk) begin
        if (wr_count != 2'd0) begin
            q_reg[tail_reg] <= wr_res0;
        end
        if (wr_count == 2'd2) begin
            q_reg[tail_reg + 2'd1] <= wr_res1;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue occupancy out of range");

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_count != 2'd0 |-> count_reg <= 3'd2)
        else $error("result queue written without room");

    a_ptr_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 3'd0 || count_reg == 3'd4) |-> head_reg == tail_reg)
        else $error("result queue pointers inconsistent");

endmodule

/* hdl/bracket_matching_run_length_tokenizer.sv */
// Bracket-matching run-length tokenizer.
// Input channel (s_valid/s_ready): one source byte per transaction, with
// s_end_of_source marking the last byte of a program. Bytes other than the
// eight tokens are dropped; runs of + - < > are merged into one counted
// operation; [ and ] are matched through a bracket stack.
// Result channel (m_valid/m_ready): one operation per transaction, carrying
// kind, argument, status, last_of_run (last result of its byte) and
// program_done (last result of the final byte).
// A byte's results enter the result queue on acceptance; with the queue
// empty, its first result is offered the cycle after. One byte per cycle is
// taken while m_ready stays high and each byte gives at most one result;
// bytes giving two outrun the single result port, draining one transaction
// a cycle from a four-entry result queue. The bracket stack is a chain of
// STACK_DEPTH cells shifting one place per push or pop at any bracket depth.
// Reset clears all control state; the stack cells hold no reset value and
// are never read before written. After an error every byte yields one
// error result until the end of the program. When the receiver stalls, the
// queue absorbs results and s_ready drops once fewer than two slots remain.
module bracket_matching_run_length_tokenizer #(
    parameter int STACK_DEPTH = bmrlt_pkg::DEF_STACK_DEPTH,
    parameter int COUNT_BITS  = bmrlt_pkg::DEF_COUNT_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bmrlt_pkg::BYTE_W-1:0]      s_source_byte,
    input  logic                              s_end_of_source,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bmrlt_pkg::KIND_W-1:0]      m_op_kind,
    output logic [bmrlt_pkg::ARG_W-1:0]       m_op_argument,
    output logic [bmrlt_pkg::STATUS_W-1:0]    m_status,
    output logic                              m_last_of_run,
    output logic                              m_program_done
);

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ARG_W   = bmrlt_pkg::ARG_W;

    // Control state
    logic                            pend_reg, pend_next;
    logic [1:0]                      pkind_reg, pkind_next;
    logic [COUNT_BITS-1:0]           run_reg, run_next;
    logic [ARG_W-1:0]                opidx_reg, opidx_next;
    logic [ARG_W-1:0]                label_reg, label_next;
    logic [DEPTH_W-1:0]              depth_reg, depth_next;
    logic                            err_reg, err_next;
    logic [bmrlt_pkg::STATUS_W-1:0]  errcode_reg, errcode_next;

    logic                   accept;
    logic                   room;
    bmrlt_pkg::tok_t        tok;
    bmrlt_pkg::res_t        res_v [2];
    bmrlt_pkg::res_t        cand;
    logic [1:0]             n_v;
    logic [1:0]             wr_count;
    logic                   push_v, pop_v;
    logic [ARG_W-1:0]       push_val;
    bmrlt_pkg::stk_ctl_t    stk_ctl;
    bmrlt_pkg::res_t        m_res;
    logic [ARG_W-1:0]       cell_data [STACK_DEPTH];

    assign s_ready = room;
    assign accept  = s_valid && s_ready;
    assign tok     = bmrlt_pkg::classify(s_source_byte);

    // Work out the results and next state of one byte
    always_comb begin
        pend_next    = pend_reg;
        pkind_next   = pkind_reg;
        run_next     = run_reg;
        opidx_next   = opidx_reg;
        label_next   = label_reg;
        depth_next   = depth_reg;
        err_next     = err_reg;
        errcode_next = errcode_reg;
        res_v[0]     = '0;
        res_v[1]     = '0;
        cand         = '0;
        n_v          = 2'd0;
        push_v       = 1'b0;
        pop_v        = 1'b0;
        push_val     = '0;

        if (err_reg) begin
            // Stopped: report the stored error
            cand.op_kind = bmrlt_pkg::OP_INC;
            cand.status  = errcode_reg;
            res_v[n_v[0]] = cand;
            n_v = n_v + 2'd1;
        end else if (tok.valid && !tok.kind[2]) begin
            // Run token: extend or restart the pending run
            if (pend_next && pkind_next == tok.kind[1:0] && !(&run_next)) begin
                run_next = run_next + COUNT_BITS'(1);
            end else begin
                if (pend_next) begin
                    cand = '0;
                    cand.op_kind     = {1'b0, pkind_next};
                    cand.op_argument = ARG_W'(run_next);
                    res_v[n_v[0]] = cand;
                    n_v = n_v + 2'd1;
                    opidx_next = opidx_next + ARG_W'(1);
                end
                pend_next  = 1'b1;
                pkind_next = tok.kind[1:0];
                run_next   = COUNT_BITS'(1);
            end
        end else if (tok.valid) begin
            // Other token: flush the run first
            if (pend_next) begin
                cand = '0;
                cand.op_kind     = {1'b0, pkind_next};
                cand.op_argument = ARG_W'(run_next);
                res_v[n_v[0]] = cand;
                n_v = n_v + 2'd1;
                opidx_next = opidx_next + ARG_W'(1);
                pend_next  = 1'b0;
                run_next   = '0;
            end
            cand = '0;
            cand.op_kind = tok.kind;
            if (tok.kind == bmrlt_pkg::OP_OPEN) begin
                if (depth_reg == DEPTH_W'(STACK_DEPTH)) begin
                    err_next     = 1'b1;
                    errcode_next = bmrlt_pkg::ST_OVERFLOW;
                    cand.status  = bmrlt_pkg::ST_OVERFLOW;
                end else begin
                    push_v           = 1'b1;
                    push_val         = opidx_next + ARG_W'(1);
                    depth_next       = depth_reg + DEPTH_W'(1);
                    cand.op_argument = label_reg;
                    label_next       = label_reg + ARG_W'(1);
                    opidx_next       = opidx_next + ARG_W'(1);
                end
            end else if (tok.kind == bmrlt_pkg::OP_CLOSE) begin
                if (depth_reg == '0) begin
                    err_next     = 1'b1;
                    errcode_next = bmrlt_pkg::ST_UNDERFLOW;
                    cand.status  = bmrlt_pkg::ST_UNDERFLOW;
                end else begin
                    pop_v            = 1'b1;
                    depth_next       = depth_reg - DEPTH_W'(1);
                    cand.op_argument = cell_data[0];
                    opidx_next       = opidx_next + ARG_W'(1);
                end
            end else begin
                opidx_next = opidx_next + ARG_W'(1);
            end
            res_v[n_v[0]] = cand;
            n_v = n_v + 2'd1;
        end

        // Flush the run still pending at the end of the source
        if (s_end_of_source && !err_next && pend_next) begin
            cand = '0;
            cand.op_kind     = {1'b0, pkind_next};
            cand.op_argument = ARG_W'(run_next);
            res_v[n_v[0]] = cand;
            n_v = n_v + 2'd1;
        end

        // Mark the final result of this byte
        if (n_v == 2'd2) begin
            res_v[1].last_of_run  = 1'b1;
            res_v[1].program_done = s_end_of_source;
        end else if (n_v == 2'd1) begin
            res_v[0].last_of_run  = 1'b1;
            res_v[0].program_done = s_end_of_source;
        end

        // Return to the reset state after the final byte
        if (s_end_of_source) begin
            pend_next    = 1'b0;
            pkind_next   = '0;
            run_next     = '0;
            opidx_next   = '0;
            label_next   = '0;
            depth_next   = '0;
            err_next     = 1'b0;
            errcode_next = bmrlt_pkg::ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            pkind_reg   <= '0;
            run_reg     <= '0;
            opidx_reg   <= '0;
            label_reg   <= '0;
            depth_reg   <= '0;
            err_reg     <= 1'b0;
            errcode_reg <= bmrlt_pkg::ST_OK;
        end else if (accept) begin
            pend_reg    <= pend_next;
            pkind_reg   <= pkind_next;
            run_reg     <= run_next;
            opidx_reg   <= opidx_next;
            label_reg   <= label_next;
            depth_reg   <= depth_next;
            err_reg     <= err_next;
            errcode_reg <= errcode_next;
        end
    end

    // Bracket stack: chain of cells, top of stack in the first cell
    assign stk_ctl.push = accept && push_v;
    assign stk_ctl.pop  = accept && pop_v;

    generate
        for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
            logic [ARG_W-1:0] upper_d;
            logic [ARG_W-1:0] lower_d;
            if (i == 0) begin : g_top
                assign upper_d = push_val;
            end else begin : g_mid
                assign upper_d = cell_data[i-1];
            end
            if (i == STACK_DEPTH - 1) begin : g_bottom
                assign lower_d = cell_data[i];
            end else begin : g_inner
                assign lower_d = cell_data[i+1];
            end
            bmrlt_cell u_cell (
                .aclk       (aclk),
                .ctl        (stk_ctl),
                .upper_data (upper_d),
                .lower_data (lower_d),
                .data       (cell_data[i])
            );
        end
    endgenerate

    // Result queue
    assign wr_count = accept ? n_v : 2'd0;

    bmrlt_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_count (wr_count),
        .wr_res0  (res_v[0]),
        .wr_res1  (res_v[1]),
        .room     (room),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_op_kind      = m_res.op_kind;
    assign m_op_argument  = m_res.op_argument;
    assign m_status       = m_res.status;
    assign m_last_of_run  = m_res.last_of_run;
    assign m_program_done = m_res.program_done;

    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("bracket stack depth beyond capacity");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_source |=> depth_reg == '0 && !pend_reg && !err_reg)
        else $error("state not cleared after final byte");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        err_reg |-> errcode_reg != bmrlt_pkg::ST_OK)
        else $error("error stop without error code");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> run_reg != '0)
        else $error("pending run with zero count");

endmodule
